### rtl/sfvg_pkg.sv
// ----------------------------------------------------------------------------
// sfvg_pkg: shared types and constants
// Queue entry layout, fixed-point angle constants and the arctangent table
// used by the sector fan vertex generator.
// ----------------------------------------------------------------------------
package sfvg_pkg;

    localparam int unsigned ANGLE_W   = 17;
    localparam int unsigned RADIUS_W  = 16;
    localparam int unsigned IDX_W     = 7;
    localparam int unsigned POS_W     = 17;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX_Q8 = 17'd92160;
    localparam logic [IDX_W-1:0]   SEG_CAP      = 7'd125;

    // Register byte addresses
    localparam logic [2:0] ADDR_RADIUS = 3'd0;
    localparam logic [2:0] ADDR_SWEEP  = 3'd4;

    // Divider: numerator is (angle * i) << 17 | segments, 41 bits
    localparam int unsigned DIV_BITS = 41;
    localparam int unsigned QUOT_W   = 34;

    localparam logic signed [34:0] DEG90_Q24  = 35'sd1509949440;
    localparam logic signed [34:0] DEG180_Q24 = 35'sd3019898880;
    localparam logic signed [34:0] DEG360_Q24 = 35'sd6039797760;

    localparam logic signed [18:0] GAIN_Q16 = 19'sd39797;
    localparam logic signed [17:0] UNIT_Q16 = 18'sd65536;
    localparam int unsigned ATAN_N = 24;

    localparam logic [30:0] ATAN_Q24 [ATAN_N] = '{
        31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
        31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
        31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
        31'd234684,    31'd117342,    31'd58671,     31'd29335,
        31'd14668,     31'd7334,      31'd3667,      31'd1833,
        31'd917,       31'd458,       31'd229,       31'd115
    };

    typedef struct packed {
        logic             centre;
        logic             valid;
        logic [IDX_W-1:0] count;
        logic [IDX_W-1:0] step;
        logic [IDX_W-1:0] segs;
    } item_t;

    function automatic logic [ANGLE_W-1:0] clamp_angle(input logic [ANGLE_W-1:0] a);
        clamp_angle = (a > ANGLE_MAX_Q8) ? ANGLE_MAX_Q8 : a;
    endfunction

endpackage

### rtl/sfvg_front.sv
// ----------------------------------------------------------------------------
// sfvg_front: request classifier
// Works out segment count, vertex count and index range for each request
// and pushes the classified beat into the work queue.
// ----------------------------------------------------------------------------
module sfvg_front #(
    parameter int unsigned SEGMENT_DEGREES = 4
) (
    input  logic                              push,
    input  logic [sfvg_pkg::IDX_W-1:0]        vertex_index,
    input  logic [sfvg_pkg::RADIUS_W-1:0]     radius,
    input  logic [sfvg_pkg::ANGLE_W-1:0]      sweep,
    input  logic                              q_full,
    output logic                              q_wr,
    output sfvg_pkg::item_t                   q_item
);

    localparam longint unsigned UNIT  = longint'(SEGMENT_DEGREES) * 256;
    localparam int unsigned     SH    = 34;
    localparam longint unsigned RECIP = ((64'd1 << SH) + UNIT - 1) / UNIT;

    logic [sfvg_pkg::ANGLE_W-1:0] ang;
    logic [17:0]                  num;
    logic [45:0]                  seg_prod;
    logic [11:0]                  segs_raw;
    logic [sfvg_pkg::IDX_W-1:0]   segs;
    logic                         empty_fan;

    assign ang = sfvg_pkg::clamp_angle(sweep);
    // ceil(ang / UNIT) through a reciprocal multiply, exact for 17-bit angles
    assign num      = 18'(ang) + 18'(UNIT - 1);
    assign seg_prod = 46'(num) * 46'(RECIP);
    assign segs_raw = seg_prod[SH+11:SH];
    assign segs     = (segs_raw > 12'(sfvg_pkg::SEG_CAP)) ? sfvg_pkg::SEG_CAP
                                                          : segs_raw[6:0];
    assign empty_fan = (radius == '0) || (ang == '0);

    always_comb
    begin
        q_item.segs   = segs;
        q_item.count  = empty_fan ? '0 : segs + 7'd2;
        q_item.valid  = vertex_index < q_item.count;
        q_item.centre = vertex_index == '0;
        q_item.step   = vertex_index - 7'd1;
    end

    assign q_wr = push && !q_full;

endmodule

### rtl/sfvg_queue.sv
// ----------------------------------------------------------------------------
// sfvg_queue: front-to-back work queue
// Short register queue of classified beats between the classifier and the
// compute pipeline.
// ----------------------------------------------------------------------------
module sfvg_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  sfvg_pkg::item_t wr_item,
    input  logic            rd,
    output sfvg_pkg::item_t rd_item,
    output logic            full,
    output logic            empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sfvg_pkg::item_t mem_reg [DEPTH];
    logic [PW-1:0]   wp_reg, wp_next;
    logic [PW-1:0]   rp_reg, rp_next;
    logic [PW:0]     cnt_reg, cnt_next;

    assign full    = cnt_reg == (PW+1)'(DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_item = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (wr)
        begin
            wp_next = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
        end
        if (rd)
        begin
            rp_next = (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
        end
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

endmodule

### rtl/sfvg_back.sv
// ----------------------------------------------------------------------------
// sfvg_back: vertex compute pipeline
// Vertex angle by a bit-per-stage divider, sine and cosine by a pipelined
// CORDIC, then radius scaling into a result register. One global advance.
// ----------------------------------------------------------------------------
module sfvg_back #(
    parameter int unsigned CORDIC_STAGES = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [sfvg_pkg::RADIUS_W-1:0] radius,
    input  logic [sfvg_pkg::ANGLE_W-1:0]  sweep,
    input  logic                          q_empty,
    input  sfvg_pkg::item_t               q_item,
    output logic                          q_rd,
    input  logic                          pop,
    output logic                          empty,
    output logic [sfvg_pkg::IDX_W-1:0]    vertex_count,
    output logic                          index_valid,
    output logic [sfvg_pkg::POS_W-1:0]    pos_x_q4,
    output logic [sfvg_pkg::POS_W-1:0]    pos_y_q4
);

    localparam int unsigned NS = (CORDIC_STAGES > sfvg_pkg::ATAN_N) ? sfvg_pkg::ATAN_N
                                                                      : CORDIC_STAGES;
    localparam int unsigned NB = sfvg_pkg::DIV_BITS;
    localparam int unsigned QW = sfvg_pkg::QUOT_W;

    typedef struct packed {
        logic                       v;
        logic                       centre;
        logic                       valid;
        logic [sfvg_pkg::IDX_W-1:0] count;
    } meta_t;

    logic                         adv;
    logic [sfvg_pkg::ANGLE_W-1:0] ang;

    // divider stages
    meta_t                      dm_reg    [NB+1];
    logic [NB-1:0]              dnum_reg  [NB+1];
    logic [7:0]                 drem_reg  [NB+1];
    logic [QW-1:0]              dq_reg    [NB+1];
    logic [sfvg_pkg::IDX_W-1:0] dsegs_reg [NB+1];

    // angle reduction
    meta_t              rm_reg;
    logic signed [34:0] rz_reg;
    logic signed [34:0] rz_sum;

    // CORDIC stages
    meta_t              cm_reg   [NS+1];
    logic signed [18:0] cx_reg   [NS+1];
    logic signed [18:0] cy_reg   [NS+1];
    logic signed [34:0] cz_reg   [NS+1];
    logic               cneg_reg [NS+1];

    // sin/cos, product and result stages
    meta_t              sm_reg;
    logic signed [17:0] sin_reg, cos_reg;
    logic signed [18:0] xn, yn;
    meta_t              pm_reg;
    logic signed [34:0] rs_reg, rc_reg;
    logic signed [16:0] rad_s;
    logic signed [19:0] rs_rnd, rc_rnd;
    logic signed [21:0] px_s, py_s;
    logic [sfvg_pkg::POS_W-1:0] px, py;

    logic                       out_v_reg;
    logic [sfvg_pkg::IDX_W-1:0] cnt_out_reg;
    logic                       vld_out_reg;
    logic [sfvg_pkg::POS_W-1:0] px_out_reg, py_out_reg;

    assign ang   = sfvg_pkg::clamp_angle(sweep);
    assign adv   = !out_v_reg || pop;
    assign q_rd  = adv && !q_empty;
    assign empty = !out_v_reg;

    // ---------------- load: angle * step, build numerator ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dm_reg[0] <= '0;
        end
        else if (adv)
        begin
            dm_reg[0].v      <= !q_empty;
            dm_reg[0].centre <= q_item.centre;
            dm_reg[0].valid  <= q_item.valid;
            dm_reg[0].count  <= q_item.count;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dnum_reg[0]  <= {24'(ang) * 24'(q_item.step), 17'(q_item.segs)};
            drem_reg[0]  <= '0;
            dq_reg[0]    <= '0;
            dsegs_reg[0] <= q_item.segs;
        end
    end

    // ---------------- restoring divider, one quotient bit a stage --------
    for (genvar s = 0; s < NB; s++)
    begin : g_div
        logic [7:0] d;
        logic [8:0] t;
        logic       ge;

        assign d  = {dsegs_reg[s], 1'b0};
        assign t  = {drem_reg[s], dnum_reg[s][NB-1]};
        assign ge = t >= {1'b0, d};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dm_reg[s+1] <= '0;
            end
            else if (adv)
            begin
                dm_reg[s+1] <= dm_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dnum_reg[s+1]  <= dnum_reg[s] << 1;
                drem_reg[s+1]  <= ge ? 8'(t - {1'b0, d}) : t[7:0];
                dq_reg[s+1]    <= {dq_reg[s][QW-2:0], ge};
                dsegs_reg[s+1] <= dsegs_reg[s];
            end
        end
    end

    // ---------------- reduce to -180..180 --------------------------------
    assign rz_sum = 35'(dq_reg[NB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rm_reg <= '0;
        end
        else if (adv)
        begin
            rm_reg <= dm_reg[NB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rz_reg <= (rz_sum > sfvg_pkg::DEG180_Q24) ? rz_sum - sfvg_pkg::DEG360_Q24
                                                      : rz_sum;
        end
    end

    // ---------------- fold into -90..90 ----------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cm_reg[0] <= '0;
        end
        else if (adv)
        begin
            cm_reg[0] <= rm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg[0] <= sfvg_pkg::GAIN_Q16;
            cy_reg[0] <= '0;
            if (rz_reg > sfvg_pkg::DEG90_Q24)
            begin
                cz_reg[0]   <= rz_reg - sfvg_pkg::DEG180_Q24;
                cneg_reg[0] <= 1'b1;
            end
            else if (rz_reg < -sfvg_pkg::DEG90_Q24)
            begin
                cz_reg[0]   <= rz_reg + sfvg_pkg::DEG180_Q24;
                cneg_reg[0] <= 1'b1;
            end
            else
            begin
                cz_reg[0]   <= rz_reg;
                cneg_reg[0] <= 1'b0;
            end
        end
    end

    // ---------------- CORDIC rotation stages -----------------------------
    for (genvar k = 0; k < NS; k++)
    begin : g_cordic
        logic signed [18:0] dx, dy;
        logic signed [34:0] at;

        if (k == 0)
        begin : g_first
            assign dx = cy_reg[k];
            assign dy = cx_reg[k];
        end
        else
        begin : g_rest
            localparam logic signed [25:0] RND = 26'sd1 <<< (k - 1);
            logic signed [25:0] yw, xw;
            assign yw = 26'(cy_reg[k]) + RND;
            assign xw = 26'(cx_reg[k]) + RND;
            assign dx = 19'(yw >>> k);
            assign dy = 19'(xw >>> k);
        end

        assign at = 35'(sfvg_pkg::ATAN_Q24[k]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                cm_reg[k+1] <= '0;
            end
            else if (adv)
            begin
                cm_reg[k+1] <= cm_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                cneg_reg[k+1] <= cneg_reg[k];
                if (!cz_reg[k][34])
                begin
                    cx_reg[k+1] <= cx_reg[k] - dx;
                    cy_reg[k+1] <= cy_reg[k] + dy;
                    cz_reg[k+1] <= cz_reg[k] - at;
                end
                else
                begin
                    cx_reg[k+1] <= cx_reg[k] + dx;
                    cy_reg[k+1] <= cy_reg[k] - dy;
                    cz_reg[k+1] <= cz_reg[k] + at;
                end
            end
        end
    end

    // ---------------- unfold and clamp to +-1.0 --------------------------
    assign xn = cneg_reg[NS] ? -cx_reg[NS] : cx_reg[NS];
    assign yn = cneg_reg[NS] ? -cy_reg[NS] : cy_reg[NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sm_reg <= '0;
            pm_reg <= '0;
        end
        else if (adv)
        begin
            sm_reg <= cm_reg[NS];
            pm_reg <= sm_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (yn > 19'(sfvg_pkg::UNIT_Q16))
                sin_reg <= sfvg_pkg::UNIT_Q16;
            else if (yn < -19'(sfvg_pkg::UNIT_Q16))
                sin_reg <= -sfvg_pkg::UNIT_Q16;
            else
                sin_reg <= 18'(yn);
            if (xn > 19'(sfvg_pkg::UNIT_Q16))
                cos_reg <= sfvg_pkg::UNIT_Q16;
            else if (xn < -19'(sfvg_pkg::UNIT_Q16))
                cos_reg <= -sfvg_pkg::UNIT_Q16;
            else
                cos_reg <= 18'(xn);
            rs_reg <= 35'(rad_s) * 35'(sin_reg);
            rc_reg <= 35'(rad_s) * 35'(cos_reg);
        end
    end

    // ---------------- scale by radius and place -------------------------
    assign rad_s  = signed'({1'b0, radius});
    assign rs_rnd = 20'((36'(rs_reg) + 36'sd32768) >>> 16);
    assign rc_rnd = 20'((36'(rc_reg) + 36'sd32768) >>> 16);
    assign px_s   = 22'(rad_s) + 22'(rs_rnd);
    assign py_s   = 22'(rad_s) - 22'(rc_rnd);

    always_comb
    begin
        if (px_s < 0)
            px = '0;
        else if (px_s > 22'sd131071)
            px = '1;
        else
            px = px_s[16:0];
        if (py_s < 0)
            py = '0;
        else if (py_s > 22'sd131071)
            py = '1;
        else
            py = py_s[16:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_v_reg <= pm_reg.v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cnt_out_reg <= pm_reg.count;
            vld_out_reg <= pm_reg.valid;
            if (!pm_reg.valid)
            begin
                px_out_reg <= '0;
                py_out_reg <= '0;
            end
            else if (pm_reg.centre)
            begin
                px_out_reg <= 17'(radius);
                py_out_reg <= 17'(radius);
            end
            else
            begin
                px_out_reg <= px;
                py_out_reg <= py;
            end
        end
    end

    assign vertex_count = cnt_out_reg;
    assign index_valid  = vld_out_reg;
    assign pos_x_q4     = px_out_reg;
    assign pos_y_q4     = py_out_reg;

endmodule

### rtl/sector_fan_vertex_generator_top.sv
// ----------------------------------------------------------------------------
// sector_fan_vertex_generator_top: triangle fan vertex generator
// Answers one fan vertex (count, range flag, x, y) per requested index for
// a sector set by radius and sweep registers.
//
//   channel  direction  handshake                  payload
//   request  in         push / full                vertex_index
//   result   out        pop / empty                vertex_count, index_valid,
//                                                  pos_x_q4, pos_y_q4
//   config   in         psel/penable/pwrite/pready radius_q4 @0, sweep_angle_q8 @4
//
// One beat is accepted per cycle while the queue is not full. Latency is set
// by the one-bit-per-stage angle divider and the CORDIC stages (capped at 24
// CORDIC stages). A stalled result freezes the whole compute pipeline; the
// 4-entry queue keeps taking requests until it fills. Reset clears both
// registers and all valid state.
// ----------------------------------------------------------------------------
module sector_fan_vertex_generator_top #(
    parameter int unsigned SEGMENT_DEGREES = 4,
    parameter int unsigned CORDIC_STAGES   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          push,
    output logic                          full,
    input  logic [sfvg_pkg::IDX_W-1:0]    vertex_index,
    output logic                          empty,
    input  logic                          pop,
    output logic [sfvg_pkg::IDX_W-1:0]    vertex_count,
    output logic                          index_valid,
    output logic [sfvg_pkg::POS_W-1:0]    pos_x_q4,
    output logic [sfvg_pkg::POS_W-1:0]    pos_y_q4
);

    logic [sfvg_pkg::RADIUS_W-1:0] radius_reg;
    logic [sfvg_pkg::ANGLE_W-1:0]  sweep_reg;
    logic                          cfg_wr;
    logic                          q_wr, q_rd, q_full, q_empty;
    sfvg_pkg::item_t               q_in, q_out;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            sweep_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            if ({paddr[2], 2'b00} == sfvg_pkg::ADDR_RADIUS)
                radius_reg <= pwdata[sfvg_pkg::RADIUS_W-1:0];
            else
                sweep_reg <= pwdata[sfvg_pkg::ANGLE_W-1:0];
        end
    end

    always_comb
    begin
        if ({paddr[2], 2'b00} == sfvg_pkg::ADDR_SWEEP)
            prdata = 32'(sweep_reg);
        else
            prdata = 32'(radius_reg);
    end

    assign full = q_full;

    sfvg_front #(
        .SEGMENT_DEGREES(SEGMENT_DEGREES)
    ) u_front (
        .push         (push),
        .vertex_index (vertex_index),
        .radius       (radius_reg),
        .sweep        (sweep_reg),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_item       (q_in)
    );

    sfvg_queue #(
        .DEPTH(4)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_item (q_in),
        .rd      (q_rd),
        .rd_item (q_out),
        .full    (q_full),
        .empty   (q_empty)
    );

    sfvg_back #(
        .CORDIC_STAGES(CORDIC_STAGES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .radius       (radius_reg),
        .sweep        (sweep_reg),
        .q_empty      (q_empty),
        .q_item       (q_out),
        .q_rd         (q_rd),
        .pop          (pop),
        .empty        (empty),
        .vertex_count (vertex_count),
        .index_valid  (index_valid),
        .pos_x_q4     (pos_x_q4),
        .pos_y_q4     (pos_y_q4)
    );

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: sector fan vertex generator testbench
// Programs radius and sweep over APB, streams vertex index requests in
// bursts, and checks every result beat against a fixed-point CORDIC
// predictor held in a small scoreboard class.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int SEG_DEG   = 4;
    localparam int STAGES    = 16;
    localparam int LATENCY   = 2 + 41 + STAGES + 4;
    localparam int MAX_CYCLES = 400000;
    localparam int N_RANDOM  = 1800;

    typedef struct {
        logic [6:0]  count;
        logic        valid;
        logic [16:0] px;
        logic [16:0] py;
    } vertex_t;

    class vertex_scoreboard;
        longint radius;
        longint sweep;
        vertex_t pending[$];
        int mismatches;
        int errors;

        function longint rnd_shift(longint v, int s);
            longint r;
            if (s == 0)
                return v;
            r = (v + (64'sd1 <<< (s - 1))) >>> s;
            return r;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function void rotate(longint theta, output longint s, output longint c);
            longint x, y, z, nx, dx, dy;
            bit neg;
            x = 39797;
            y = 0;
            z = theta;
            neg = 0;
            if (z > 180 * 64'sd16777216)
                z -= 360 * 64'sd16777216;
            if (z > 90 * 64'sd16777216)
            begin
                z -= 180 * 64'sd16777216;
                neg = 1;
            end
            else if (z < -90 * 64'sd16777216)
            begin
                z += 180 * 64'sd16777216;
                neg = 1;
            end
            for (int k = 0; k < STAGES; k++)
            begin
                dx = rnd_shift(y, k);
                dy = rnd_shift(x, k);
                if (z >= 0)
                begin
                    nx = x - dx;
                    y = y + dy;
                    z -= longint'(sfvg_pkg::ATAN_Q24[k]);
                end
                else
                begin
                    nx = x + dx;
                    y = y - dy;
                    z += longint'(sfvg_pkg::ATAN_Q24[k]);
                end
                x = nx;
            end
            if (neg)
            begin
                x = -x;
                y = -y;
            end
            s = clamp(y, -65536, 65536);
            c = clamp(x, -65536, 65536);
        endfunction

        function void note_request(logic [6:0] idx);
            vertex_t e;
            longint ang, segs, cnt, th, s, c;
            ang = sweep > 92160 ? 92160 : sweep;
            segs = 0;
            cnt = 0;
            e = '{count: 0, valid: 0, px: 0, py: 0};
            if (radius != 0 && ang != 0)
            begin
                segs = (ang + SEG_DEG * 256 - 1) / (SEG_DEG * 256);
                if (segs < 1) segs = 1;
                if (segs > 125) segs = 125;
                cnt = segs + 2;
            end
            e.count = cnt[6:0];
            if (idx < cnt)
            begin
                e.valid = 1;
                if (idx == 0)
                begin
                    e.px = radius[16:0];
                    e.py = radius[16:0];
                end
                else
                begin
                    th = (ang * (idx - 1) * 131072 + segs) / (2 * segs);
                    rotate(th, s, c);
                    e.px = 17'(clamp(radius + rnd_shift(radius * s, 16), 0, 131071));
                    e.py = 17'(clamp(radius - rnd_shift(radius * c, 16), 0, 131071));
                end
            end
            pending.push_back(e);
        endfunction

        function void check_result(vertex_t got);
            vertex_t e;
            if (pending.size() == 0)
            begin
                errors++;
                $display("unexpected result beat: count=%0d", got.count);
                return;
            end
            e = pending.pop_front();
            if (e.count !== got.count || e.valid !== got.valid ||
                e.px !== got.px || e.py !== got.py)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                        e.count, e.valid, e.px, e.py,
                        got.count, got.valid, got.px, got.py);
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push = 0;
    logic        full;
    logic [6:0]  vertex_index = '0;
    logic        empty;
    logic        pop = 0;
    logic [6:0]  vertex_count;
    logic        index_valid;
    logic [16:0] pos_x_q4, pos_y_q4;

    vertex_scoreboard fan_sb = new();
    int  cycle_count = 0;
    bit  hold_off = 0;
    bit  random_pop = 1;

    sector_fan_vertex_generator_top #(
        .SEGMENT_DEGREES(SEG_DEG),
        .CORDIC_STAGES(STAGES)
    ) dut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check on the accepting edge, then pick the next pop level
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            fan_sb.check_result('{count: vertex_count, valid: index_valid,
                                  px: pos_x_q4, py: pos_y_q4});
        if (hold_off)
            pop <= 0;
        else if (random_pop)
            pop <= (($urandom % 8) < 5) || (cycle_count % 512 < 64);
        else
            pop <= 1;
    end

    task automatic reg_write(logic [2:0] addr, logic [31:0] data);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    task automatic set_sector(int unsigned r, int unsigned a);
        reg_write(sfvg_pkg::ADDR_RADIUS, r);
        reg_write(sfvg_pkg::ADDR_SWEEP, a);
        fan_sb.radius = r & 16'hFFFF;
        fan_sb.sweep = a & 17'h1FFFF;
    endtask

    // hold push until the beat is taken; push stays high across back-to-back beats
    task automatic send_index(logic [6:0] idx, bit keep);
        push <= 1;
        vertex_index <= idx;
        @(posedge clk);
        while (full)
            @(posedge clk);
        fan_sb.note_request(idx);
        if (!keep)
            push <= 0;
    endtask

    task automatic send_burst(int n, int maxidx);
        int len;
        int gap;
        logic [6:0] idx;
        while (n > 0)
        begin
            len = $urandom_range(1, 12);
            if (len > n) len = n;
            gap = ($urandom_range(0, 3) != 0) ? int'($urandom_range(0, 6)) : 0;
            for (int k = 0; k < len; k++)
            begin
                idx = 7'($urandom_range(0, maxidx));
                send_index(idx, (k != len - 1) || (gap == 0 && n > 1));
                n--;
            end
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        while (fan_sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    initial
    begin
        int unsigned rr, aa;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // empty fan after reset: everything out of range
        send_index(7'd0, 1'b1);
        send_index(7'd1, 1'b1);
        send_index(7'd127, 1'b0);
        drain();

        set_sector(16'hFFFF, 92160);
        for (int i = 0; i < 8; i++)
            send_index(7'(i), 1'b1);
        send_index(7'd91, 1'b1);
        send_index(7'd92, 1'b1);
        send_index(7'd127, 1'b0);
        drain();

        set_sector(1, 1);
        for (int i = 0; i < 4; i++)
            send_index(7'(i), i != 3);
        drain();

        // above 360 is clamped; radius zero gives an empty fan
        set_sector(800, 17'h1FFFF);
        send_index(7'd46, 1'b1);
        send_index(7'd91, 1'b0);
        drain();
        set_sector(0, 30000);
        send_index(7'd0, 1'b1);
        send_index(7'd5, 1'b0);
        drain();

        // long receiver hold-off while the sender keeps offering beats
        set_sector(1234, 23040);
        hold_off = 1;
        fork
            send_burst(120, 30);
            begin
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join
        drain();

        for (int ph = 0; ph < 12; ph++)
        begin
            rr = (ph % 4 == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 65535);
            aa = (ph % 5 == 0) ? $urandom_range(92000, 131071) : $urandom_range(1, 92160);
            if (ph == 3) rr = 65535;
            if (ph == 6) aa = 1024;
            random_pop = (ph % 3 != 2);
            set_sector(rr, aa);
            send_burst(N_RANDOM / 12, (ph % 4 == 1) ? 127 : 95);
            drain();
        end

        if (fan_sb.errors == 0 && fan_sb.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

### sector_fan_vertex_generator_top.f
rtl/sfvg_pkg.sv
rtl/sfvg_front.sv
rtl/sfvg_queue.sv
rtl/sfvg_back.sv
rtl/sector_fan_vertex_generator_top.sv
verif/tb_top.sv
